// ===== hw/rtl/mcpg_pkg.sv =====
// Shared constants, types and helpers of the midpoint circle pixel generator.
// Used by the request and pixel interfaces and by every RTL module.
package mcpg_pkg;

	localparam int CoordBits  = 12;
	localparam int ColorBits  = 16;
	localparam int RadiusW    = CoordBits - 1;
	localparam int PixW       = CoordBits + 1;
	localparam int ErrW       = CoordBits + 2;
	localparam int CalcW      = CoordBits + 2;
	localparam int ErrShift   = 4;
	localparam int PitchW     = 13;
	localparam int FrameW     = 25;
	localparam int OffsetW    = 25;
	localparam int CfgDataW   = 25;
	localparam int CfgIdxW    = 1;
	localparam int ProdW      = CalcW + PitchW + 1;
	localparam int OffW       = (ProdW + 1 > FrameW + 1) ? ProdW + 1 : FrameW + 1;

	localparam logic [PitchW-1:0] PitchReset = PitchW'(1024);
	localparam logic [FrameW-1:0] FrameReset = FrameW'(786432);

	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	localparam cfg_idx_t CfgLinePitch   = cfg_idx_t'(0);
	localparam cfg_idx_t CfgFramePixels = cfg_idx_t'(1);

	typedef logic mode_t;
	localparam mode_t ModeStart = 1'b0;
	localparam mode_t ModeStep  = 1'b1;

	typedef logic [2:0] octant_t;
	localparam octant_t LastOctant = 3'd7;

	typedef struct packed {
		logic signed [CoordBits-1:0] x;
		logic signed [CoordBits-1:0] y;
		logic signed [CoordBits-1:0] cx;
		logic signed [CoordBits-1:0] cy;
		logic [ColorBits-1:0]        color;
		logic                        done;
	} job_t;

	typedef struct packed {
		logic signed [CalcW-1:0] dx;
		logic signed [CalcW-1:0] dy;
	} delta_t;

	// Mirror (x, y) into octant k, in emission order.
	function automatic delta_t mirror(input octant_t k, input logic signed [CoordBits-1:0] x,
		input logic signed [CoordBits-1:0] y);
		logic signed [CalcW-1:0] xe;
		logic signed [CalcW-1:0] ye;
		delta_t d;
		xe = CalcW'(x);
		ye = CalcW'(y);
		case (k)
			3'd0: begin d.dx = xe;  d.dy = ye;  end
			3'd1: begin d.dx = ye;  d.dy = xe;  end
			3'd2: begin d.dx = -xe; d.dy = ye;  end
			3'd3: begin d.dx = xe;  d.dy = -ye; end
			3'd4: begin d.dx = -xe; d.dy = -ye; end
			3'd5: begin d.dx = -ye; d.dy = -xe; end
			3'd6: begin d.dx = -ye; d.dy = xe;  end
			default: begin d.dx = ye; d.dy = -xe; end
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/mcpg_req_if.sv =====
// Request channel of the circle generator: start or step commands.
// Depends on mcpg_pkg for field widths.
interface mcpg_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic signed [mcpg_pkg::CoordBits-1:0] center_x;
	logic signed [mcpg_pkg::CoordBits-1:0] center_y;
	logic [mcpg_pkg::RadiusW-1:0]          radius;
	logic [mcpg_pkg::ColorBits-1:0]        color;

	modport source (output valid, mode, center_x, center_y, radius, color, input ready);
	modport sink (input valid, mode, center_x, center_y, radius, color, output ready);
endinterface

// ===== hw/rtl/mcpg_pix_if.sv =====
// Pixel channel of the circle generator: one pixel write per valid/ready transfer.
// Depends on mcpg_pkg for field widths.
interface mcpg_pix_if;
	logic                                valid;
	logic                                ready;
	logic signed [mcpg_pkg::PixW-1:0]    pixel_x;
	logic signed [mcpg_pkg::PixW-1:0]    pixel_y;
	logic signed [mcpg_pkg::OffsetW-1:0] pixel_offset;
	logic                                in_bounds;
	logic [mcpg_pkg::ColorBits-1:0]      pixel_color;
	logic                                last;
	logic                                done_res;

	modport source (output valid, pixel_x, pixel_y, pixel_offset, in_bounds, pixel_color, last,
		done_res, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_offset, in_bounds, pixel_color, last,
		done_res, output ready);
endinterface

// ===== hw/rtl/mcpg_stepper.sv =====
// Rasterizer state: takes start and step requests, advances x, y and error,
// and hands each emitting step to the pixel pipeline. Depends on mcpg_pkg, mcpg_req_if.
module mcpg_stepper (
	input  logic              clk,
	input  logic              arst_n,
	mcpg_req_if.sink          req,
	output mcpg_pkg::job_t    job,
	output logic              job_vld,
	input  logic              job_take
);

	logic signed [mcpg_pkg::CoordBits-1:0] cur_x_q;
	logic signed [mcpg_pkg::CoordBits-1:0] cur_y_q;
	logic signed [mcpg_pkg::ErrW-1:0]      err_q;
	logic signed [mcpg_pkg::CoordBits-1:0] org_x_q;
	logic signed [mcpg_pkg::CoordBits-1:0] org_y_q;
	logic [mcpg_pkg::ColorBits-1:0]        color_q;
	logic                                  active_q;
	mcpg_pkg::job_t                        job_q;
	logic                                  job_vld_q;

	logic                                  accept;
	logic                                  is_step;
	logic                                  can_emit;
	logic                                  job_load;
	logic signed [mcpg_pkg::CoordBits-1:0] ny;
	logic signed [mcpg_pkg::ErrW-1:0]      e1;
	logic signed [mcpg_pkg::ErrW:0]        t;
	logic                                  take;
	logic signed [mcpg_pkg::ErrW-1:0]      nerr;
	logic signed [mcpg_pkg::CoordBits-1:0] nx;
	logic                                  fin;

	assign req.ready = !job_vld_q || job_take;
	assign accept    = req.valid && req.ready;
	assign is_step   = (req.mode == mcpg_pkg::ModeStep);
	assign can_emit  = !(cur_x_q < cur_y_q);
	assign job_load  = accept && is_step && active_q && can_emit;

	always_comb begin
		ny   = cur_y_q + mcpg_pkg::CoordBits'(1);
		e1   = err_q + mcpg_pkg::ErrW'(ny);
		t    = (mcpg_pkg::ErrW + 1)'(e1) - (mcpg_pkg::ErrW + 1)'(cur_x_q);
		take = !t[mcpg_pkg::ErrW];
		nerr = take ? t[mcpg_pkg::ErrW-1:0] : e1;
		nx   = take ? cur_x_q - mcpg_pkg::CoordBits'(1) : cur_x_q;
		fin  = nx < ny;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			org_x_q   <= '0;
			org_y_q   <= '0;
			color_q   <= '0;
			active_q  <= 1'b0;
			job_vld_q <= 1'b0;
		end else begin
			job_vld_q <= job_load || (job_vld_q && !job_take);
			if (accept) begin
				if (!is_step) begin
					cur_x_q  <= mcpg_pkg::CoordBits'(req.radius);
					cur_y_q  <= '0;
					err_q    <= mcpg_pkg::ErrW'(req.radius >> mcpg_pkg::ErrShift);
					org_x_q  <= req.center_x;
					org_y_q  <= req.center_y;
					color_q  <= req.color;
					active_q <= 1'b1;
				end else if (active_q && !can_emit) begin
					active_q <= 1'b0;
				end else if (active_q) begin
					cur_x_q  <= nx;
					cur_y_q  <= ny;
					err_q    <= nerr;
					active_q <= !fin;
				end
			end
		end
	end

	// Snapshot of the pixel job; origin and color are copied so a start may follow at once.
	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q.x     <= cur_x_q;
			job_q.y     <= cur_y_q;
			job_q.cx    <= org_x_q;
			job_q.cy    <= org_y_q;
			job_q.color <= color_q;
			job_q.done  <= fin;
		end
	end

	assign job     = job_q;
	assign job_vld = job_vld_q;

	a_active_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !cur_x_q[mcpg_pkg::CoordBits-1])
		else $error("active circle with negative x");

	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_step && active_q && can_emit |=> job_vld_q)
		else $error("emitting step did not load a pixel job");

	a_start_activates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_step |=> active_q)
		else $error("start request did not activate the rasterizer");

endmodule

// ===== hw/rtl/mcpg_pixel_pipe.sv =====
// Pixel pipeline: issues the eight mirrored pixels of a job, one a cycle while not stalled,
// computes offset and bound flag over two register stages. Depends on mcpg_pkg, mcpg_pix_if.
module mcpg_pixel_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcpg_pkg::job_t                job,
	input  logic                          job_vld,
	output logic                          job_take,
	input  logic [mcpg_pkg::PitchW-1:0]   line_pitch,
	input  logic [mcpg_pkg::FrameW-1:0]   frame_pixels,
	mcpg_pix_if.source                    pix
);

	mcpg_pkg::octant_t                     k_q;
	logic                                  vld_s1;
	logic signed [mcpg_pkg::CalcW-1:0]     px_s1;
	logic signed [mcpg_pkg::ProdW-1:0]     prod_s1;
	logic [mcpg_pkg::ColorBits-1:0]        color_s1;
	logic                                  last_s1;
	logic                                  done_s1;
	logic                                  vld_s2;
	logic signed [mcpg_pkg::PixW-1:0]      pixel_x_s2;
	logic signed [mcpg_pkg::PixW-1:0]      pixel_y_s2;
	logic signed [mcpg_pkg::OffsetW-1:0]   offset_s2;
	logic                                  in_bounds_s2;
	logic [mcpg_pkg::ColorBits-1:0]        color_s2;
	logic                                  last_s2;
	logic                                  done_s2;
	logic signed [mcpg_pkg::PixW-1:0]      py_s1;

	logic                                  adv1;
	logic                                  adv2;
	logic                                  issue;
	mcpg_pkg::delta_t                      d;
	logic signed [mcpg_pkg::CalcW-1:0]     px_w;
	logic signed [mcpg_pkg::CalcW-1:0]     py_w;
	logic signed [mcpg_pkg::ProdW-1:0]     prod_w;
	logic signed [mcpg_pkg::OffW-1:0]      off_w;
	logic                                  inb_w;

	assign adv2     = !vld_s2 || pix.ready;
	assign adv1     = !vld_s1 || adv2;
	assign issue    = job_vld && adv1;
	assign job_take = issue && (k_q == mcpg_pkg::LastOctant);

	always_comb begin
		d      = mcpg_pkg::mirror(k_q, job.x, job.y);
		px_w   = mcpg_pkg::CalcW'(job.cx) + d.dx;
		py_w   = mcpg_pkg::CalcW'(job.cy) + d.dy;
		prod_w = mcpg_pkg::ProdW'(py_w) * mcpg_pkg::ProdW'($signed({1'b0, line_pitch}));
	end

	always_comb begin
		off_w = mcpg_pkg::OffW'(prod_s1) + mcpg_pkg::OffW'(px_s1);
		inb_w = !off_w[mcpg_pkg::OffW-1] &&
			(off_w[mcpg_pkg::OffW-2:0] < (mcpg_pkg::OffW - 1)'(frame_pixels));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= k_q + mcpg_pkg::octant_t'(1);
			end
			if (adv1) begin
				vld_s1 <= issue;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			px_s1    <= px_w;
			py_s1    <= py_w[mcpg_pkg::PixW-1:0];
			prod_s1  <= prod_w;
			color_s1 <= job.color;
			last_s1  <= (k_q == mcpg_pkg::LastOctant);
			done_s1  <= job.done;
		end
		if (adv2 && vld_s1) begin
			pixel_x_s2   <= px_s1[mcpg_pkg::PixW-1:0];
			pixel_y_s2   <= py_s1;
			offset_s2    <= off_w[mcpg_pkg::OffsetW-1:0];
			in_bounds_s2 <= inb_w;
			color_s2     <= color_s1;
			last_s2      <= last_s1;
			done_s2      <= done_s1;
		end
	end

	assign pix.valid        = vld_s2;
	assign pix.pixel_x      = pixel_x_s2;
	assign pix.pixel_y      = pixel_y_s2;
	assign pix.pixel_offset = offset_s2;
	assign pix.in_bounds    = in_bounds_s2;
	assign pix.pixel_color  = color_s2;
	assign pix.last         = last_s2;
	assign pix.done_res     = done_s2;

	a_partial_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != '0 |-> job_vld)
		else $error("pixel job dropped before all octants issued");

	a_job_kept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		issue && k_q != mcpg_pkg::LastOctant |=> job_vld && k_q == $past(k_q) + 3'd1)
		else $error("octant sequence broken");

endmodule

// ===== hw/rtl/midpoint_circle_pixel_generator.sv =====
// Midpoint circle rasterizer: configuration registers, stepper and pixel pipeline.
// Depends on mcpg_pkg, mcpg_req_if, mcpg_pix_if, mcpg_stepper, mcpg_pixel_pipe.
//
// A start request loads center, radius and color and produces no pixels. Each step
// request emits the eight mirrored pixels of the current point, one per cycle while
// the pixel channel is ready; the single pixel issue port of the output pipeline
// sets that rate. The next step request is taken in the cycle the eighth pixel of
// the previous one issues. Start requests and steps that emit nothing are accepted
// whenever no pixel job is pending. Issued pixels pass through registers s1 and s2.
// Write line_pitch and frame_pixels only while the block is idle.
module midpoint_circle_pixel_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  mcpg_pkg::cfg_idx_t               cfg_index,
	input  logic [mcpg_pkg::CfgDataW-1:0]    cfg_data,
	mcpg_req_if.sink                         req,
	mcpg_pix_if.source                       pix
);

	logic [mcpg_pkg::PitchW-1:0] line_pitch_q;
	logic [mcpg_pkg::FrameW-1:0] frame_pixels_q;
	mcpg_pkg::job_t              job;
	logic                        job_vld;
	logic                        job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pitch_q   <= mcpg_pkg::PitchReset;
			frame_pixels_q <= mcpg_pkg::FrameReset;
		end else if (cfg_we) begin
			case (cfg_index)
				mcpg_pkg::CfgLinePitch:   line_pitch_q   <= cfg_data[mcpg_pkg::PitchW-1:0];
				mcpg_pkg::CfgFramePixels: frame_pixels_q <= cfg_data[mcpg_pkg::FrameW-1:0];
				default: ;
			endcase
		end
	end

	mcpg_stepper u_stepper (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.job      (job),
		.job_vld  (job_vld),
		.job_take (job_take)
	);

	mcpg_pixel_pipe u_pixel_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.job_vld      (job_vld),
		.job_take     (job_take),
		.line_pitch   (line_pitch_q),
		.frame_pixels (frame_pixels_q),
		.pix          (pix)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the midpoint circle pixel generator: random and directed
// start/step requests, a built-in rasterizer predictor and a pixel scoreboard.
// Depends on mcpg_pkg, mcpg_req_if, mcpg_pix_if and the generator RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mcpg_pkg::*;

	typedef struct packed {
		mode_t                       mode;
		logic signed [CoordBits-1:0] center_x;
		logic signed [CoordBits-1:0] center_y;
		logic [RadiusW-1:0]          radius;
		logic [ColorBits-1:0]        color;
	} circle_req_t;

	typedef struct packed {
		logic signed [PixW-1:0]    pixel_x;
		logic signed [PixW-1:0]    pixel_y;
		logic signed [OffsetW-1:0] pixel_offset;
		logic                      in_bounds;
		logic [ColorBits-1:0]      pixel_color;
		logic                      last;
		logic                      done_res;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CfgLinePitch;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	circle_req_t req_item = '0;
	logic pix_ready = 1'b0;
	logic calm = 1'b0;

	mcpg_req_if req_ch();
	mcpg_pix_if pix_ch();

	assign req_ch.valid = req_valid;
	assign req_ch.mode = req_item.mode;
	assign req_ch.center_x = req_item.center_x;
	assign req_ch.center_y = req_item.center_y;
	assign req_ch.radius = req_item.radius;
	assign req_ch.color = req_item.color;
	assign pix_ch.ready = pix_ready;

	midpoint_circle_pixel_generator i_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.req (req_ch),
		.pix (pix_ch)
	);

	always #4 clk = ~clk;

	// predictor state and configuration copy
	logic signed [CoordBits-1:0] pt_x = '0;
	logic signed [CoordBits-1:0] pt_y = '0;
	logic signed [ErrW-1:0] err_acc = '0;
	logic signed [CoordBits-1:0] org_x = '0;
	logic signed [CoordBits-1:0] org_y = '0;
	logic [ColorBits-1:0] ink = '0;
	logic drawing = 1'b0;
	logic [PitchW-1:0] pitch_cfg = PitchReset;
	logic [FrameW-1:0] frame_cfg = FrameReset;

	circle_req_t requests_queued[$];
	pixel_t pixels_due[$];
	int errors = 0;
	int requests_taken = 0;
	int pixels_seen = 0;
	int circles_started = 0;
	int settings_used = 1;

	function automatic void rasterize_step(input circle_req_t rq);
		logic signed [CoordBits-1:0] x0;
		logic signed [CoordBits-1:0] y0;
		longint t;
		longint xl;
		longint yl;
		longint px;
		longint py;
		longint off;
		longint dx[8];
		longint dy[8];
		bit finished;
		pixel_t p;
		if (rq.mode == ModeStart) begin
			org_x = rq.center_x;
			org_y = rq.center_y;
			ink = rq.color;
			pt_x = {1'b0, rq.radius};
			pt_y = '0;
			err_acc = ErrW'({1'b0, rq.radius} >> ErrShift);
			drawing = 1'b1;
			circles_started++;
			return;
		end
		if (!drawing)
			return;
		x0 = pt_x;
		y0 = pt_y;
		if (x0 < y0) begin
			drawing = 1'b0;
			return;
		end
		pt_y = y0 + 1;
		err_acc = err_acc + pt_y;
		t = longint'(err_acc) - longint'(pt_x);
		if (t >= 0) begin
			err_acc = ErrW'(t);
			pt_x = pt_x - 1;
		end
		finished = pt_x < pt_y;
		if (finished)
			drawing = 1'b0;
		xl = x0;
		yl = y0;
		dx = '{xl, yl, -xl, xl, -xl, -yl, -yl, yl};
		dy = '{yl, xl, yl, -yl, -yl, -xl, xl, -xl};
		for (int k = 0; k < 8; k++) begin
			px = longint'(org_x) + dx[k];
			py = longint'(org_y) + dy[k];
			off = py * longint'(pitch_cfg) + px;
			p.pixel_x = PixW'(px);
			p.pixel_y = PixW'(py);
			p.pixel_offset = OffsetW'(off);
			p.in_bounds = (off >= 0) && (off < longint'(frame_cfg));
			p.pixel_color = ink;
			p.last = octant_t'(k) == LastOctant;
			p.done_res = finished;
			pixels_due.push_back(p);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ch.ready) begin
				rasterize_step(req_item);
				requests_taken++;
			end
			if (!req_valid || req_ch.ready) begin
				if (requests_queued.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
					req_item <= requests_queued.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			pix_ready <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ready) begin
				pixels_seen++;
				got.pixel_x = pix_ch.pixel_x;
				got.pixel_y = pix_ch.pixel_y;
				got.pixel_offset = pix_ch.pixel_offset;
				got.in_bounds = pix_ch.in_bounds;
				got.pixel_color = pix_ch.pixel_color;
				got.last = pix_ch.last;
				got.done_res = pix_ch.done_res;
				if (pixels_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected pixel: x=%0d y=%0d off=%0d", got.pixel_x,
							got.pixel_y, got.pixel_offset);
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("pixel %0d mismatch: exp x=%0d y=%0d off=%0d in=%b",
								pixels_seen, want.pixel_x, want.pixel_y,
								want.pixel_offset, want.in_bounds);
							$display("  exp col=%h last=%b done=%b", want.pixel_color,
								want.last, want.done_res);
							$display("  got x=%0d y=%0d off=%0d in=%b", got.pixel_x,
								got.pixel_y, got.pixel_offset, got.in_bounds);
							$display("  got col=%h last=%b done=%b", got.pixel_color,
								got.last, got.done_res);
						end
					end
				end
			end
			pix_ready <= calm || $urandom_range(99) >= 32;
		end
	end

	function automatic circle_req_t make_req(input mode_t m, input int cx, input int cy,
		input int r, input int c);
		circle_req_t rq;
		rq.mode = m;
		rq.center_x = CoordBits'(cx);
		rq.center_y = CoordBits'(cy);
		rq.radius = RadiusW'(r);
		rq.color = ColorBits'(c);
		return rq;
	endfunction

	task automatic queue_steps(input int n);
		for (int i = 0; i < n; i++)
			requests_queued.push_back(make_req(ModeStep, $urandom, $urandom, $urandom,
				$urandom));
	endtask

	task automatic queue_circles(input int quota);
		int added;
		int r;
		int nsteps;
		circle_req_t rq;
		added = 0;
		while (added < quota) begin
			if ($urandom_range(99) < 10) begin
				queue_steps(1);
				added++;
			end else begin
				rq = make_req(ModeStart, $urandom, $urandom, $urandom, $urandom);
				if ($urandom_range(1)) begin
					rq.center_x = CoordBits'($urandom_range(600));
					rq.center_y = CoordBits'($urandom_range(600));
				end
				if ($urandom_range(99) < 10) begin
					nsteps = $urandom_range(1, 3);
				end else begin
					r = $urandom_range(24);
					rq.radius = RadiusW'(r);
					nsteps = r * 3 / 4 + 2;
					if ($urandom_range(99) < 15)
						nsteps = $urandom_range(nsteps - 1);
				end
				requests_queued.push_back(rq);
				queue_steps(nsteps);
				added += 1 + nsteps;
			end
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (requests_queued.size() != 0 || req_valid || pixels_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgLinePitch)
			pitch_cfg = val[PitchW-1:0];
		else
			frame_cfg = val[FrameW-1:0];
	endtask

	initial begin
		int pitch_set[6];
		int frame_set[6];
		pitch_set = '{1, 0, 4096, 8191, 640, 1};
		frame_set = '{0, 16777216, 786432, 33554431, 307200, 0};
		pitch_set[5] = $urandom_range(1, 4096);
		frame_set[5] = $urandom_range(16777216);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step while idle, degenerate radius, extremes, restart while active
		queue_steps(1);
		requests_queued.push_back(make_req(ModeStart, 0, 0, 0, 0));
		queue_steps(2);
		requests_queued.push_back(make_req(ModeStart, -2048, -2048, 2047, 65535));
		queue_steps(2);
		requests_queued.push_back(make_req(ModeStart, 2047, 2047, 5, 'h5A5A));
		queue_steps(6);
		requests_queued.push_back(make_req(ModeStart, 2047, -2048, 1, 'hA5A5));
		queue_steps(2);
		requests_queued.push_back(make_req(ModeStart, -2048, 2047, 16, 'h1234));
		queue_steps(6);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CfgLinePitch, CfgDataW'(pitch_set[ph]));
			write_reg(CfgFramePixels, CfgDataW'(frame_set[ph]));
			settings_used++;
			calm = ph == 2;
			queue_circles(50);
			settle();
			calm = 1'b0;
		end

		if (pixels_due.size() != 0) begin
			errors += pixels_due.size();
			$display("%0d expected pixels never arrived", pixels_due.size());
		end
		$display("covered %0d requests, %0d circles, %0d pixels over %0d register settings",
			requests_taken, circles_started, pixels_seen, settings_used);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d requests queued and %0d pixels outstanding",
			requests_queued.size(), pixels_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
